// ===== rtl/negative_cycle_finder_core_defines.svh =====
// Assertion macros used by ncf_seq.sv, the RTL file that carries checks.
// Each macro expects clk and rst_n to be in scope.
`ifndef NEGATIVE_CYCLE_FINDER_CORE_DEFINES_SVH
`define NEGATIVE_CYCLE_FINDER_CORE_DEFINES_SVH

// Same-cycle implication.
`define NCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ncf_pkg.sv =====
package ncf_pkg;

    localparam int WEIGHT_W = 31;
    localparam int DIST_W   = 64;
    localparam int CNT_W    = 6;
    localparam int VTX_W    = 6;

    // Matrix entry that marks a missing edge
    localparam logic signed [WEIGHT_W-1:0] NO_EDGE = 31'sd1000000000;
    // Lowest distance kept after a relaxation
    localparam logic signed [DIST_W-1:0] DIST_FLOOR = -64'sd1000000000000000000;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_I,
        S_HOLD_I,
        S_RD_E,
        S_ADD,
        S_UPD,
        S_WALK,
        S_TSTART,
        S_TRACE,
        S_EMIT_RD,
        S_OUT,
        S_NONE
    } ncf_state_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic rd_sel_i;
        logic latch_i;
        logic add_en;
        logic upd_en;
    } ncf_relax_ctl_t;

endpackage

// ===== rtl/ncf_weight_mem.sv =====
module ncf_weight_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic signed [ncf_pkg::WEIGHT_W-1:0] wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic signed [ncf_pkg::WEIGHT_W-1:0] rd_data
);
    import ncf_pkg::*;

    logic signed [WEIGHT_W-1:0] mem [DEPTH];
    logic signed [WEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ncf_relax_unit.sv =====
module ncf_relax_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ncf_pkg::ncf_relax_ctl_t             ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0]     row,
    input  logic [$clog2(MAX_VERTICES)-1:0]     col,
    input  logic signed [ncf_pkg::WEIGHT_W-1:0] w,
    output logic                                relax
);
    import ncf_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    logic signed [DIST_W-1:0]  dist_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]   dv_reg;
    logic                      rd_ok_reg;
    logic signed [DIST_W-1:0]  rd_data_reg;
    logic signed [DIST_W-1:0]  di_reg;
    logic signed [DIST_W-1:0]  cand_reg;
    logic                      absent_reg;
    logic signed [DIST_W-1:0]  dist_rd;
    logic signed [DIST_W-1:0]  new_dist;
    logic signed [DIST_W-1:0]  w_ext;
    logic [VW-1:0]             rd_addr;
    logic                      wr_en;

    assign rd_addr  = ctl.rd_sel_i ? row : col;
    // An entry not written in this run reads as zero
    assign dist_rd  = rd_ok_reg ? rd_data_reg : '0;
    assign relax    = !absent_reg && (cand_reg < dist_rd);
    assign new_dist = (cand_reg < DIST_FLOOR) ? DIST_FLOOR : cand_reg;
    assign w_ext    = $signed({{(DIST_W-WEIGHT_W){w[WEIGHT_W-1]}}, w});
    assign wr_en    = ctl.upd_en && relax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg    <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                dv_reg <= '0;
            end
            else if (wr_en)
            begin
                dv_reg[col] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_ok_reg <= dv_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= dist_mem[rd_addr];
        end
        if (wr_en)
        begin
            dist_mem[col] <= new_dist;
        end
        // Keep the row distance current when a self loop lowers it mid-row
        if (ctl.latch_i)
        begin
            di_reg <= dist_rd;
        end
        else if (wr_en && (row == col))
        begin
            di_reg <= new_dist;
        end
        if (ctl.add_en)
        begin
            cand_reg   <= w_ext + di_reg;
            absent_reg <= (w == NO_EDGE);
        end
    end

endmodule

// ===== rtl/ncf_seq.sv =====
`include "negative_cycle_finder_core_defines.svh"

module ncf_seq #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]             n,
    input  logic                                          relax,
    output logic                                          idle,
    output ncf_pkg::ncf_relax_ctl_t                       ctl,
    output logic [$clog2(MAX_VERTICES)-1:0]               row,
    output logic [$clog2(MAX_VERTICES)-1:0]               col,
    output logic                                          w_rd_en,
    output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]  w_rd_addr,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic                                          has_cycle,
    output logic [ncf_pkg::CNT_W-1:0]                     cycle_length,
    output logic [ncf_pkg::VTX_W-1:0]                     vertex,
    output logic                                          last
);
    import ncf_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES+1);
    localparam int LW = $clog2(MAX_VERTICES+2);
    localparam int AW = $clog2(MAX_VERTICES*MAX_VERTICES);

    ncf_state_t state_reg, state_next;

    logic [VW-1:0]           i_reg, j_reg, pass_reg, k_reg;
    logic [AW-1:0]           addr_reg;
    logic                    changed_reg;
    logic [VW-1:0]           v_reg, start_reg;
    logic [LW-1:0]           len_reg;
    logic [NW-1:0]           idx_reg;
    logic [MAX_VERTICES-1:0] pok_reg;
    logic [VW-1:0]           parent_reg [MAX_VERTICES];
    logic [VW-1:0]           stack_mem [MAX_VERTICES+1];
    logic [VW-1:0]           stack_q_reg;

    logic [NW-1:0] n_m1;
    logic          j_last, i_last, pass_last, k_last;
    logic [VW-1:0] par_v;
    logic          ok_v;
    logic          len_full;
    logic          at_start;
    logic          push_v;
    logic          stk_we;
    logic [NW-1:0] stk_addr;
    logic [VW-1:0] stk_wdata;

    assign n_m1      = n - NW'(1);
    assign j_last    = (NW'(j_reg) == n_m1);
    assign i_last    = (NW'(i_reg) == n_m1);
    assign pass_last = (NW'(pass_reg) == n_m1);
    assign k_last    = (NW'(k_reg) == n_m1);
    assign par_v     = parent_reg[v_reg];
    assign ok_v      = pok_reg[v_reg];
    assign len_full  = (len_reg >= LW'(n));
    assign at_start  = (v_reg == start_reg);
    assign push_v    = (state_reg == S_TRACE) && !at_start && !len_full && ok_v;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    state_next = S_RD_I;
                end
            end
            S_RD_I:   state_next = S_HOLD_I;
            S_HOLD_I: state_next = S_RD_E;
            S_RD_E:   state_next = S_ADD;
            S_ADD:    state_next = S_UPD;
            S_UPD:
            begin
                priority if (!j_last)
                begin
                    state_next = S_RD_E;
                end
                else if (!(i_last && pass_last))
                begin
                    state_next = S_RD_I;
                end
                else if (changed_reg || relax)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_NONE;
                end
            end
            S_WALK:
            begin
                priority if (!ok_v)
                begin
                    state_next = S_NONE;
                end
                else if (k_last)
                begin
                    state_next = S_TSTART;
                end
            end
            S_TSTART: state_next = ok_v ? S_TRACE : S_NONE;
            S_TRACE:
            begin
                priority if (at_start)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (len_full || !ok_v)
                begin
                    state_next = S_NONE;
                end
            end
            S_EMIT_RD: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (idx_reg == '0) ? S_LOAD : S_EMIT_RD;
                end
            end
            S_NONE:
            begin
                if (out_ready)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl          = '0;
        w_rd_en      = 1'b0;
        idle         = 1'b0;
        out_valid    = 1'b0;
        has_cycle    = 1'b0;
        cycle_length = '0;
        vertex       = '0;
        last         = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                idle      = 1'b1;
                ctl.clear = start;
            end
            S_RD_I:
            begin
                ctl.rd_en    = 1'b1;
                ctl.rd_sel_i = 1'b1;
            end
            S_HOLD_I: ctl.latch_i = 1'b1;
            S_RD_E:
            begin
                ctl.rd_en = 1'b1;
                w_rd_en   = 1'b1;
            end
            S_ADD: ctl.add_en = 1'b1;
            S_UPD: ctl.upd_en = 1'b1;
            S_OUT:
            begin
                out_valid    = 1'b1;
                has_cycle    = 1'b1;
                cycle_length = CNT_W'(len_reg);
                vertex       = VTX_W'(stack_q_reg) + VTX_W'(1);
                last         = (idx_reg == '0);
            end
            S_NONE:
            begin
                out_valid = 1'b1;
                last      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign row       = i_reg;
    assign col       = j_reg;
    assign w_rd_addr = addr_reg;

    // Cycle stack write port
    always_comb
    begin
        stk_we    = 1'b0;
        stk_addr  = len_reg[NW-1:0];
        stk_wdata = v_reg;
        if (state_reg == S_TSTART)
        begin
            stk_we   = 1'b1;
            stk_addr = '0;
        end
        else if (state_reg == S_TRACE)
        begin
            stk_we = at_start || push_v;
            if (at_start)
            begin
                stk_wdata = start_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            i_reg       <= '0;
            j_reg       <= '0;
            pass_reg    <= '0;
            k_reg       <= '0;
            addr_reg    <= '0;
            changed_reg <= 1'b0;
            v_reg       <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            pok_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (start)
                    begin
                        i_reg       <= '0;
                        j_reg       <= '0;
                        pass_reg    <= '0;
                        addr_reg    <= '0;
                        changed_reg <= 1'b0;
                        v_reg       <= '0;
                        pok_reg     <= '0;
                    end
                end
                S_UPD:
                begin
                    k_reg <= '0;
                    if (relax)
                    begin
                        pok_reg[j_reg] <= 1'b1;
                        v_reg          <= j_reg;
                    end
                    // Drop the change mark at each new pass
                    if (j_last && i_last && !pass_last)
                    begin
                        changed_reg <= 1'b0;
                    end
                    else if (relax)
                    begin
                        changed_reg <= 1'b1;
                    end
                    if (j_last)
                    begin
                        j_reg <= '0;
                        if (i_last)
                        begin
                            i_reg    <= '0;
                            addr_reg <= '0;
                            if (!pass_last)
                            begin
                                pass_reg <= pass_reg + VW'(1);
                            end
                        end
                        else
                        begin
                            i_reg    <= i_reg + VW'(1);
                            addr_reg <= addr_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        j_reg    <= j_reg + VW'(1);
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                S_WALK:
                begin
                    v_reg <= par_v;
                    k_reg <= k_reg + VW'(1);
                end
                S_TSTART:
                begin
                    start_reg <= v_reg;
                    len_reg   <= LW'(1);
                    v_reg     <= par_v;
                end
                S_TRACE:
                begin
                    if (at_start)
                    begin
                        idx_reg <= len_reg[NW-1:0];
                        len_reg <= len_reg + LW'(1);
                    end
                    else if (push_v)
                    begin
                        len_reg <= len_reg + LW'(1);
                        v_reg   <= par_v;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg - NW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_UPD) && relax)
        begin
            parent_reg[j_reg] <= i_reg;
        end
        if (stk_we)
        begin
            stack_mem[stk_addr] <= stk_wdata;
        end
        if (state_reg == S_EMIT_RD)
        begin
            stack_q_reg <= stack_mem[idx_reg];
        end
    end

    `NCF_ASSERT_IMP(a_vertex_range, out_valid && has_cycle, (vertex != '0) && (vertex <= VTX_W'(n)), "cycle vertex outside vertex count")
    `NCF_ASSERT_IMP(a_len_range, out_valid && has_cycle, (cycle_length >= CNT_W'(2)) && (cycle_length <= CNT_W'(n) + CNT_W'(1)), "cycle length out of range")
    `NCF_ASSERT_NXT(a_run_start, start, (state_reg == S_RD_I) && !changed_reg && (pok_reg == '0), "run did not start clean")
    `NCF_ASSERT_NXT(a_parent_set, (state_reg == S_UPD) && relax, pok_reg[$past(j_reg)], "relaxed vertex lacks parent")

endmodule

// ===== rtl/negative_cycle_finder_core.sv =====
// Negative cycle finder: Bellman-Ford relaxation with cycle trace-back.
// Configuration: write vertex_count on the cfg channel while the block is idle;
// a write restarts matrix loading at entry 0. Values of 0 act as 1, values above
// MAX_VERTICES act as MAX_VERTICES.
// Input: one matrix weight per word, row-major, one word per cycle while loading.
// 1000000000 marks a missing edge. The last of n*n words starts a run.
// Run: n passes over all n*n entries; for each row the row distance is fetched,
// then each entry is read, added and compared on the shared 64-bit add/compare
// unit and written back if it relaxes, then a walk-back and a trace through the
// parent table follow. in_ready and cfg_ready are low for the whole run; in_ready
// also stays low while cfg_valid is high.
// Output: either a single no-cycle word, or the cycle as cycle_length words
// (start vertex repeated at the end), each read from the cycle stack memory
// before it is offered, last set on the final word. A stalled receiver simply
// holds the current word; the block waits.
// Reset clears the control state and sets vertex_count to 1; the weight matrix
// holds no defined contents until loaded.
module negative_cycle_finder_core #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ncf_pkg::CNT_W-1:0]           vertex_count,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ncf_pkg::WEIGHT_W-1:0] weight,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                has_cycle,
    output logic [ncf_pkg::CNT_W-1:0]           cycle_length,
    output logic [ncf_pkg::VTX_W-1:0]           vertex,
    output logic                                last
);
    import ncf_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES+1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(DEPTH+1);

    logic [CNT_W-1:0]         vcount_reg;
    logic [EW-1:0]            entry_reg;
    logic [NW-1:0]            n_eff;
    logic [EW-1:0]            nsq;
    logic [EW-1:0]            entry_inc;
    logic                     cfg_acc;
    logic                     in_acc;
    logic                     start;
    logic                     idle;
    logic                     relax;
    ncf_relax_ctl_t           ctl;
    logic [VW-1:0]            row, col;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic signed [WEIGHT_W-1:0] w_rd_data;

    // Clamp the vertex count into the supported range
    always_comb
    begin
        priority if (vcount_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (vcount_reg > CNT_W'(MAX_VERTICES))
        begin
            n_eff = NW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = NW'(vcount_reg);
        end
    end

    assign nsq       = EW'(n_eff) * EW'(n_eff);
    assign entry_inc = entry_reg + EW'(1);
    assign cfg_ready = idle;
    // Hold off weights while a cfg word is offered so the two never share an edge
    assign in_ready  = idle && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;
    // Fire the run on the word that completes the matrix
    assign start     = in_acc && !cfg_acc && (entry_inc == nsq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CNT_W'(1);
            entry_reg  <= '0;
        end
        else if (cfg_acc)
        begin
            vcount_reg <= vertex_count;
            entry_reg  <= '0;
        end
        else if (in_acc)
        begin
            entry_reg <= (entry_inc == nsq) ? '0 : entry_inc;
        end
    end

    ncf_weight_mem #(
        .DEPTH(DEPTH)
    ) u_weight_mem (
        .clk    (clk),
        .wr_en  (in_acc),
        .wr_addr(entry_reg[AW-1:0]),
        .wr_data(weight),
        .rd_en  (w_rd_en),
        .rd_addr(w_rd_addr),
        .rd_data(w_rd_data)
    );

    ncf_relax_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_relax (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .row  (row),
        .col  (col),
        .w    (w_rd_data),
        .relax(relax)
    );

    ncf_seq #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .n           (n_eff),
        .relax       (relax),
        .idle        (idle),
        .ctl         (ctl),
        .row         (row),
        .col         (col),
        .w_rd_en     (w_rd_en),
        .w_rd_addr   (w_rd_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .has_cycle   (has_cycle),
        .cycle_length(cycle_length),
        .vertex      (vertex),
        .last        (last)
    );

endmodule
